// ===== rtl/sca_pkg.sv =====
// Types, constants and helper functions shared by the ATR parser files.
package sca_pkg;

  localparam int unsigned MaxAtrLengthDefault = 33;

  localparam logic [7:0]  TsDirect     = 8'h3b;
  localparam logic [7:0]  TsInverse    = 8'h3f;
  localparam logic [7:0]  Ta1Baud9600  = 8'h11;
  localparam logic [7:0]  Ta1Baud19200 = 8'h12;
  localparam logic [7:0]  Ta1Baud38400 = 8'h13;
  localparam logic [7:0]  IfscMax      = 8'd254;
  localparam logic [11:0] TimeoutMin   = 12'd500;
  localparam logic [11:0] TimeoutMax   = 12'd3000;
  localparam logic [4:0]  GroupMax     = 5'd31;
  localparam logic [4:0]  GroupFirstT1 = 5'd3;
  localparam logic [5:0]  ByteCountMax = 6'd63;

  localparam logic [1:0] BaudCode9600  = 2'd0;
  localparam logic [1:0] BaudCode19200 = 2'd1;
  localparam logic [1:0] BaudCode38400 = 2'd2;

  localparam logic [3:0] ProtoT0 = 4'd0;
  localparam logic [3:0] ProtoT1 = 4'd1;

  // Configuration register indexes
  localparam logic [1:0] CfgDefaultIfsc    = 2'd0;
  localparam logic [1:0] CfgDefaultTimeout = 2'd1;
  localparam logic [1:0] CfgDefaultBaud    = 2'd2;

  typedef enum logic [2:0] {
    PH_TS    = 3'd0,
    PH_T0    = 3'd1,
    PH_IFACE = 3'd2,
    PH_HIST  = 3'd3,
    PH_TCK   = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERROR = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_OK    = 2'd1,
    ST_PROTO = 2'd2,
    ST_UNSUP = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] atr_byte;
    logic       start_req;
  } sca_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  baud_code;
    logic [7:0]  ifsc;
    logic [11:0] bwt_ms;
    logic        use_crc;
    logic [5:0]  atr_length;
  } sca_out_t;

  typedef struct packed {
    logic [7:0]  ifsc;
    logic [11:0] timeout_ms;
    logic [1:0]  baud_code;
  } sca_cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  pending;
    logic [4:0]  group_idx;
    logic [3:0]  hist_left;
    logic        non_t0;
    logic        in_t1;
    logic [7:0]  rx_xor;
    logic [5:0]  byte_count;
    logic [1:0]  baud_code;
    logic [7:0]  ifsc;
    logic [11:0] timeout_ms;
    logic        use_crc;
    status_e     status;
  } sca_state_t;

  function automatic logic [7:0] clamp_ifsc(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) r = 8'd1;
    else if (v > IfscMax) r = IfscMax;
    return r;
  endfunction

  function automatic logic [11:0] clamp_timeout(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    if (v < TimeoutMin) r = TimeoutMin;
    else if (v > TimeoutMax) r = TimeoutMax;
    return r;
  endfunction

  function automatic logic [1:0] clamp_baud(input logic [1:0] v);
    return (v > BaudCode38400) ? BaudCode38400 : v;
  endfunction

  // 100 ms << BWI, held within 500..3000 ms
  function automatic logic [11:0] bwi_timeout(input logic [3:0] bwi);
    logic [11:0] r;
    case (bwi) inside
      4'd0, 4'd1, 4'd2: r = 12'd500;
      4'd3:             r = 12'd800;
      4'd4:             r = 12'd1600;
      default:          r = TimeoutMax;
    endcase
    return r;
  endfunction

  function automatic sca_state_t clear_state(input sca_cfg_t cfg);
    sca_state_t s;
    s.phase      = PH_TS;
    s.pending    = 4'd0;
    s.group_idx  = 5'd1;
    s.hist_left  = 4'd0;
    s.non_t0     = 1'b0;
    s.in_t1      = 1'b0;
    s.rx_xor     = 8'd0;
    s.byte_count = 6'd0;
    s.baud_code  = clamp_baud(cfg.baud_code);
    s.ifsc       = clamp_ifsc(cfg.ifsc);
    s.timeout_ms = clamp_timeout(cfg.timeout_ms);
    s.use_crc    = 1'b0;
    s.status     = ST_MORE;
    return s;
  endfunction

endpackage

// ===== rtl/smart_card_atr_parser.sv =====
// Smart card answer-to-reset parser: top level with state, result and config registers.
//
// Usage: ATR bytes enter on the in_req_i channel (valid/stall), one byte per
// request; start_req set marks TS of a new ATR and clears the parse. Every
// accepted byte yields exactly one result on out_res_o: running status (need
// more, complete, protocol error, unsupported rate), the parsed rate code,
// IFSC, block timeout, CRC/LRC choice and the byte count so far.
// The result of an accepted byte is registered and valid in the next cycle.
// Throughput is one byte per cycle while the receiver does not stall; the
// parse state update is a single pass of logic between the state register
// and the result register. The input is stalled only while a result is held
// and the receiver stalls, so a stalled result stays put and nothing is lost.
// Configuration writes (default IFSC, default timeout, default rate code)
// are taken at any edge with cfg_we_i high and apply from the next start.
// Reset: asynchronous, active low; the parse expects TS, the defaults are
// 32 / 500 ms / 9600 baud and no result is pending.
module smart_card_atr_parser #(
  parameter int unsigned MAX_ATR_LENGTH = sca_pkg::MaxAtrLengthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sca_pkg::sca_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sca_pkg::sca_out_t out_res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_wdata_i
);
  import sca_pkg::*;

  localparam sca_cfg_t CfgReset = '{ifsc: 8'd32, timeout_ms: 12'd500,
                                    baud_code: BaudCode9600};

  sca_cfg_t   cfg_q;
  sca_state_t st_q;
  sca_state_t st_d;
  sca_out_t   out_q;
  logic       out_valid_q;
  logic       in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDefaultIfsc:    cfg_q.ifsc       <= cfg_wdata_i[7:0];
        CfgDefaultTimeout: cfg_q.timeout_ms <= cfg_wdata_i;
        CfgDefaultBaud:    cfg_q.baud_code  <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  sca_step #(
    .MAX_ATR_LENGTH(MAX_ATR_LENGTH)
  ) u_step (
    .state_i(st_q),
    .cfg_i  (cfg_q),
    .req_i  (in_req_i),
    .state_o(st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= clear_state(CfgReset);
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.status     <= st_d.status;
      out_q.baud_code  <= st_d.baud_code;
      out_q.ifsc       <= st_d.ifsc;
      out_q.bwt_ms     <= st_d.timeout_ms;
      out_q.use_crc    <= st_d.use_crc;
      out_q.atr_length <= st_d.byte_count;
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted byte gave no result");

  a_start_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.start_req) |=> (out_res_o.atr_length == 6'd1))
    else $error("start byte not counted as first byte");

  a_error_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_ERROR) |-> (st_q.status == ST_PROTO || st_q.status == ST_UNSUP))
    else $error("error phase without error status");

  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_DONE) |-> (st_q.status == ST_OK))
    else $error("complete phase without complete status");

  a_error_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_req_i.start_req && st_q.phase == PH_ERROR)
      |=> (st_q.status == $past(st_q.status)))
    else $error("error status not held");

endmodule

// ===== rtl/sca_step.sv =====
// Next-state logic of the ATR parser: one received byte against the parse state.
module sca_step #(
  parameter int unsigned MAX_ATR_LENGTH = sca_pkg::MaxAtrLengthDefault
) (
  input  sca_pkg::sca_state_t state_i,
  input  sca_pkg::sca_cfg_t   cfg_i,
  input  sca_pkg::sca_in_t    req_i,
  output sca_pkg::sca_state_t state_o
);
  import sca_pkg::*;

  localparam logic [5:0] MaxLen    = 6'(MAX_ATR_LENGTH);
  localparam logic [6:0] MaxLenExt = 7'(MAX_ATR_LENGTH);

  sca_state_t cur;
  sca_state_t nxt;
  logic [7:0] b;
  logic       over;
  logic       fin;
  logic       t1;
  logic       bad_ta1;
  logic [6:0] expected;

  always_comb begin
    b       = req_i.atr_byte;
    cur     = req_i.start_req ? clear_state(cfg_i) : state_i;
    nxt     = cur;
    fin     = 1'b0;
    bad_ta1 = 1'b0;
    t1      = cur.in_t1 && (cur.group_idx >= GroupFirstT1);
    over    = cur.byte_count >= MaxLen;
    if (cur.byte_count != ByteCountMax) nxt.byte_count = cur.byte_count + 6'd1;

    if (cur.phase == PH_ERROR) begin
      // latched
    end else if (cur.phase == PH_DONE || over) begin
      nxt.phase  = PH_ERROR;
      nxt.status = ST_PROTO;
    end else begin
      if (cur.phase != PH_TS) nxt.rx_xor = cur.rx_xor ^ b;
      unique case (cur.phase)
        PH_TS: begin
          if (b == TsDirect || b == TsInverse) begin
            nxt.phase = PH_T0;
          end else begin
            nxt.phase  = PH_ERROR;
            nxt.status = ST_PROTO;
          end
        end
        PH_T0: begin
          nxt.pending   = b[7:4];
          nxt.hist_left = b[3:0];
          if (b[7:4] == 4'd0) fin = 1'b1;
          else nxt.phase = PH_IFACE;
        end
        PH_IFACE: begin
          if (cur.pending[0]) begin
            nxt.pending = {cur.pending[3:1], 1'b0};
            if (cur.group_idx == 5'd1) begin
              case (b)
                Ta1Baud9600:  nxt.baud_code = BaudCode9600;
                Ta1Baud19200: nxt.baud_code = BaudCode19200;
                Ta1Baud38400: nxt.baud_code = BaudCode38400;
                default:      bad_ta1 = 1'b1;
              endcase
            end
            if (t1 && b != 8'd0 && b <= IfscMax) nxt.ifsc = b;
          end else if (cur.pending[1]) begin
            nxt.pending = {cur.pending[3:2], 2'b00};
            if (t1) nxt.timeout_ms = bwi_timeout(b[7:4]);
          end else if (cur.pending[2]) begin
            nxt.pending = {cur.pending[3], 3'b000};
            if (t1) nxt.use_crc = b[0];
          end else begin
            // TD: protocol in the low nibble, next group's presence bits above
            if (b[3:0] != ProtoT0) nxt.non_t0 = 1'b1;
            nxt.in_t1   = (b[3:0] == ProtoT1);
            nxt.pending = b[7:4];
            if (cur.group_idx < GroupMax) nxt.group_idx = cur.group_idx + 5'd1;
          end
          if (bad_ta1) begin
            nxt.phase  = PH_ERROR;
            nxt.status = ST_UNSUP;
          end else if (nxt.pending == 4'd0) begin
            fin = 1'b1;
          end
        end
        PH_HIST: begin
          if (cur.hist_left != 4'd0) nxt.hist_left = cur.hist_left - 4'd1;
          if (nxt.hist_left == 4'd0) begin
            if (cur.non_t0) begin
              nxt.phase = PH_TCK;
            end else begin
              nxt.phase  = PH_DONE;
              nxt.status = ST_OK;
            end
          end
        end
        PH_TCK: begin
          if (nxt.rx_xor == 8'd0) begin
            nxt.phase  = PH_DONE;
            nxt.status = ST_OK;
          end else begin
            nxt.phase  = PH_ERROR;
            nxt.status = ST_PROTO;
          end
        end
        default: begin
        end
      endcase
    end

    // End of the interface bytes: the whole length is now known
    expected = 7'(nxt.byte_count) + 7'(nxt.hist_left) + 7'(nxt.non_t0);
    if (fin) begin
      if (expected > MaxLenExt) begin
        nxt.phase  = PH_ERROR;
        nxt.status = ST_PROTO;
      end else if (nxt.hist_left != 4'd0) begin
        nxt.phase = PH_HIST;
      end else if (nxt.non_t0) begin
        nxt.phase = PH_TCK;
      end else begin
        nxt.phase  = PH_DONE;
        nxt.status = ST_OK;
      end
    end

    state_o = nxt;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the smart card ATR parser.
`timescale 1ns / 1ps

module tb_top;
  import sca_pkg::*;

  localparam int unsigned MaxLen     = MaxAtrLengthDefault;
  localparam int          CycleLimit = 400000;
  localparam logic [1:0]  CfgUnused  = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  sca_in_t    in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  sca_out_t   out_res;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  // mirror of the parse state
  phase_e      m_phase;
  status_e     m_status;
  logic [3:0]  m_pend;
  logic [4:0]  m_group;
  logic [3:0]  m_hist;
  logic        m_non_t0;
  logic        m_in_t1;
  logic [7:0]  m_xor;
  logic [5:0]  m_count;
  logic [1:0]  m_baud;
  logic [7:0]  m_ifsc;
  logic [11:0] m_tmo;
  logic        m_crc;
  logic [7:0]  dflt_ifsc;
  logic [11:0] dflt_tmo;
  logic [1:0]  dflt_baud;

  sca_out_t   atr_results_due[$];
  logic [7:0] atr_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 0;
  int cycle_count = 0;

  smart_card_atr_parser uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- predictor
  task automatic model_clear();
    m_phase  = PH_TS;
    m_status = ST_MORE;
    m_pend   = '0;
    m_group  = 5'd1;
    m_hist   = '0;
    m_non_t0 = 1'b0;
    m_in_t1  = 1'b0;
    m_xor    = '0;
    m_count  = '0;
    m_baud   = (dflt_baud > BaudCode38400) ? BaudCode38400 : dflt_baud;
    m_ifsc   = (dflt_ifsc == 8'd0) ? 8'd1 : ((dflt_ifsc > IfscMax) ? IfscMax : dflt_ifsc);
    m_tmo    = (dflt_tmo < TimeoutMin) ? TimeoutMin
             : ((dflt_tmo > TimeoutMax) ? TimeoutMax : dflt_tmo);
    m_crc    = 1'b0;
  endtask

  task automatic model_fail(input status_e code);
    m_phase  = PH_ERROR;
    m_status = code;
  endtask

  task automatic model_complete();
    m_phase  = PH_DONE;
    m_status = ST_OK;
  endtask

  // announced length is known once the last interface byte is in
  task automatic model_end_ifaces();
    int unsigned total;
    total = 32'(m_count) + 32'(m_hist) + 32'(m_non_t0);
    if (total > MaxLen) model_fail(ST_PROTO);
    else if (m_hist != 0) m_phase = PH_HIST;
    else if (m_non_t0) m_phase = PH_TCK;
    else model_complete();
  endtask

  task automatic parse_atr_byte(input logic [7:0] b, input logic s);
    logic        over;
    logic        t1;
    logic        bad_rate;
    logic [3:0]  proto;
    logic [3:0]  bwi;
    logic [11:0] w;
    sca_out_t    r;
    bad_rate = 1'b0;
    if (s) model_clear();
    over = (32'(m_count) >= MaxLen);
    if (m_count < ByteCountMax) m_count = m_count + 6'd1;
    if (m_phase == PH_ERROR) begin
      // status held until the next start
    end else if (m_phase == PH_DONE || over) begin
      model_fail(ST_PROTO);
    end else begin
      if (m_phase != PH_TS) m_xor = m_xor ^ b;
      case (m_phase)
        PH_TS: begin
          if (b == TsDirect || b == TsInverse) m_phase = PH_T0;
          else model_fail(ST_PROTO);
        end
        PH_T0: begin
          m_pend = b[7:4];
          m_hist = b[3:0];
          if (m_pend == 0) model_end_ifaces();
          else m_phase = PH_IFACE;
        end
        PH_IFACE: begin
          t1 = m_in_t1 && (m_group >= GroupFirstT1);
          if (m_pend[0]) begin
            m_pend[0] = 1'b0;
            if (m_group == 5'd1) begin
              case (b)
                Ta1Baud9600:  m_baud = BaudCode9600;
                Ta1Baud19200: m_baud = BaudCode19200;
                Ta1Baud38400: m_baud = BaudCode38400;
                default:      bad_rate = 1'b1;
              endcase
            end
            if (bad_rate) model_fail(ST_UNSUP);
            else if (t1 && b >= 8'd1 && b <= IfscMax) m_ifsc = b;
          end else if (m_pend[1]) begin
            m_pend[1] = 1'b0;
            if (t1) begin
              bwi = b[7:4];
              w = (bwi < 4'd5) ? (12'd100 << bwi) : TimeoutMax;
              if (w < TimeoutMin) w = TimeoutMin;
              if (w > TimeoutMax) w = TimeoutMax;
              m_tmo = w;
            end
          end else if (m_pend[2]) begin
            m_pend[2] = 1'b0;
            if (t1) m_crc = b[0];
          end else begin
            proto = b[3:0];
            if (proto != ProtoT0) m_non_t0 = 1'b1;
            m_in_t1 = (proto == ProtoT1);
            m_pend  = b[7:4];
            if (m_group < GroupMax) m_group = m_group + 5'd1;
          end
          if (!bad_rate && m_pend == 0) model_end_ifaces();
        end
        PH_HIST: begin
          if (m_hist != 0) m_hist = m_hist - 4'd1;
          if (m_hist == 0) begin
            if (m_non_t0) m_phase = PH_TCK;
            else model_complete();
          end
        end
        default: begin
          if (m_xor == 8'd0) model_complete();
          else model_fail(ST_PROTO);
        end
      endcase
    end
    r.status     = m_status;
    r.baud_code  = m_baud;
    r.ifsc       = m_ifsc;
    r.bwt_ms     = m_tmo;
    r.use_crc    = m_crc;
    r.atr_length = m_count;
    atr_results_due.push_back(r);
  endtask

  // ------------------------------------------------------------------ drivers
  task automatic send_byte(input logic [7:0] b, input logic s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= '{atr_byte: b, start_req: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_atr_byte(b, s);
    n_sent++;
  endtask

  task automatic send_atr(input int upto);
    int n;
    n = (upto < 0 || upto > atr_buf.size()) ? atr_buf.size() : upto;
    for (int i = 0; i < n; i++) send_byte(atr_buf[i], i == 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [11:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CfgDefaultIfsc:    dflt_ifsc = v[7:0];
      CfgDefaultTimeout: dflt_tmo  = v;
      CfgDefaultBaud:    dflt_baud = v[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(input logic [11:0] ifsc, input logic [11:0] tmo,
                         input logic [11:0] baud);
    cfg_write(CfgDefaultIfsc, ifsc);
    cfg_write(CfgDefaultTimeout, tmo);
    cfg_write(CfgDefaultBaud, baud);
    n_settings++;
  endtask

  task automatic cfg_random();
    logic [11:0] a, t, b;
    case ($urandom_range(5))
      0: a = 12'd1;
      1: a = 12'd254;
      2: a = 12'd0;
      3: a = 12'd255;
      default: a = 12'($urandom_range(4095));
    endcase
    case ($urandom_range(5))
      0: t = 12'd500;
      1: t = 12'd3000;
      2: t = 12'd0;
      3: t = 12'd4095;
      default: t = 12'($urandom_range(4095));
    endcase
    b = 12'($urandom_range(4095));
    cfg_all(a, t, b);
  endtask

  // drop the input valid and wait until every result is out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (atr_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ATR generator: mostly well-formed, TCK optionally corrupted
  task automatic build_atr(input bit corrupt);
    logic [3:0] y, nxt, proto, k;
    logic [7:0] v, ck;
    int         grp, ng;
    bit         nt0;
    atr_buf.delete();
    atr_buf.push_back($urandom_range(1) ? TsDirect : TsInverse);
    ng = $urandom_range(1, 4);
    y  = 4'($urandom_range(15));
    if (ng > 1 && $urandom_range(3) != 0) y[3] = 1'b1;
    k  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
    v  = {y, k};
    atr_buf.push_back(v);
    ck  = v;
    nt0 = 1'b0;
    grp = 1;
    while (y != 0) begin
      if (y[0]) begin
        if (grp == 1) begin
          case ($urandom_range(9))
            0, 1, 2: v = Ta1Baud9600;
            3, 4, 5: v = Ta1Baud19200;
            6, 7, 8: v = Ta1Baud38400;
            default: v = 8'($urandom_range(255));
          endcase
        end else begin
          case ($urandom_range(5))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = IfscMax;
            3: v = 8'd1;
            default: v = 8'($urandom_range(255));
          endcase
        end
        atr_buf.push_back(v);
        ck = ck ^ v;
      end
      if (y[1]) begin
        v = 8'($urandom_range(255));
        atr_buf.push_back(v);
        ck = ck ^ v;
      end
      if (y[2]) begin
        v = 8'($urandom_range(255));
        atr_buf.push_back(v);
        ck = ck ^ v;
      end
      if (y[3]) begin
        grp++;
        case ($urandom_range(3))
          0:       proto = ProtoT0;
          1, 2:    proto = ProtoT1;
          default: proto = 4'($urandom_range(15));
        endcase
        nxt = (grp <= ng) ? 4'($urandom_range(15)) : 4'd0;
        if (grp < ng && $urandom_range(3) != 0) nxt[3] = 1'b1;
        if (grp >= ng) nxt[3] = 1'b0;
        if (proto != ProtoT0) nt0 = 1'b1;
        v = {nxt, proto};
        atr_buf.push_back(v);
        ck = ck ^ v;
        y = nxt;
      end else begin
        y = 4'd0;
      end
    end
    repeat (k) begin
      v = 8'($urandom_range(255));
      atr_buf.push_back(v);
      ck = ck ^ v;
    end
    if (nt0) begin
      if (corrupt) ck = ck ^ 8'($urandom_range(1, 255));
      atr_buf.push_back(ck);
    end
  endtask

  // ----------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sca_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (atr_results_due.size() == 0) begin
        report_err("result with no byte outstanding");
      end else begin
        want = atr_results_due.pop_front();
        n_checked++;
        if (out_res.status !== want.status)
          report_err($sformatf("status got %0d want %0d", out_res.status, want.status));
        if (out_res.baud_code !== want.baud_code)
          report_err($sformatf("baud_code got %0d want %0d",
                               out_res.baud_code, want.baud_code));
        if (out_res.ifsc !== want.ifsc)
          report_err($sformatf("ifsc got %0d want %0d", out_res.ifsc, want.ifsc));
        if (out_res.bwt_ms !== want.bwt_ms)
          report_err($sformatf("bwt_ms got %0d want %0d",
                               out_res.bwt_ms, want.bwt_ms));
        if (out_res.use_crc !== want.use_crc)
          report_err($sformatf("use_crc got %0d want %0d", out_res.use_crc, want.use_crc));
        if (out_res.atr_length !== want.atr_length)
          report_err($sformatf("atr_length got %0d want %0d",
                               out_res.atr_length, want.atr_length));
      end
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    // first bytes after reset carry no start flag
    send_byte(TsDirect, 1'b0);
    send_byte(8'h00, 1'b0);
    // minimal ATR, then a byte after completion
    atr_buf = '{TsInverse, 8'h00, 8'h55};
    send_atr(-1);
    // bad TS, then latched
    atr_buf = '{8'h00, TsDirect};
    send_atr(-1);
    // unsupported TA1
    atr_buf = '{TsDirect, 8'h10, 8'h14};
    send_atr(-1);
    // T=1 in group three: TA3 out of range, BWI above four, CRC, good TCK
    atr_buf = '{TsDirect, 8'h80, 8'h81, 8'h71, 8'hFF, 8'h50, 8'h01, 8'hDE};
    send_atr(-1);
    // wrong TCK
    atr_buf = '{TsDirect, 8'h80, 8'h01, 8'h82};
    send_atr(-1);
    // fastest rate with historical bytes
    atr_buf = '{TsInverse, 8'h12, Ta1Baud38400, 8'hAA, 8'h55};
    send_atr(-1);
  endtask

  task automatic test_config_defaults();
    drain();
    cfg_all(12'd1, 12'd500, 12'd0);
    atr_buf = '{TsDirect, 8'h00};
    send_atr(-1);
    drain();
    cfg_all(12'd254, 12'd3000, 12'd2);
    send_atr(-1);
    drain();
    cfg_all(12'hF00, 12'd0, 12'hFF3);
    cfg_write(CfgUnused, 12'hFFF);
    send_atr(-1);
    drain();
    cfg_all(12'd255, 12'd4095, 12'd1);
    send_atr(-1);
    drain();
    // new defaults must not show until a start
    cfg_all(12'd77, 12'd1234, 12'd0);
    send_byte(8'h3B, 1'b0);
    send_byte(8'h3B, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // endless TD chain: group counter and byte counter saturate, length overrun
  task automatic test_long_chain();
    logic [3:0] p;
    atr_buf = '{TsDirect, 8'h80};
    repeat (68) begin
      p = 4'($urandom_range(15));
      atr_buf.push_back({4'h8, p});
    end
    send_atr(-1);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    build_atr(1'b0);
    send_atr(-1);
    repeat (15) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_random(input int n_items);
    int first;
    int m;
    first = n_sent;
    while (n_sent - first < n_items) begin
      m = $urandom_range(99);
      if (m < 65) begin
        build_atr(1'b0);
        send_atr(-1);
      end else if (m < 75) begin
        build_atr(1'b1);
        send_atr(-1);
      end else if (m < 85) begin
        build_atr(1'b0);
        send_atr($urandom_range(1, atr_buf.size()));
      end else if (m < 92) begin
        build_atr($urandom_range(1));
        send_atr(-1);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    dflt_ifsc = 8'd32;
    dflt_tmo  = 12'd500;
    dflt_baud = BaudCode9600;
    model_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_defaults();
    test_long_chain();
    test_backpressure();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (2) begin
        drain();
        cfg_random();
        test_random(80);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (atr_results_due.size() != 0) report_err("results still outstanding at the end");
    $display("Covered %0d ATR bytes and %0d checked results over %0d default settings,",
             n_sent, n_checked, n_settings);
    $display("with directed cases, a long TD chain, a long hold-off and four idle mixes.");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sca_pkg.sv
rtl/sca_step.sv
rtl/smart_card_atr_parser.sv
bench/tb_top.sv
